// ===== hdl/json_token_lexer_top_defines.svh =====
// Assertion macros for the JSON token lexer.
// Included by json_token_lexer_top.sv; depends on nothing else.
`ifndef JSON_TOKEN_LEXER_TOP_DEFINES_SVH
`define JSON_TOKEN_LEXER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JTL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define JTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jtl_pkg.sv =====
// Shared types and constants of the JSON token lexer.
// Used by jtl_step.sv and json_token_lexer_top.sv; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jtl_pkg;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SIGN  = 4'd1,
    M_ZERO  = 4'd2,
    M_INT   = 4'd3,
    M_DOT   = 4'd4,
    M_FRAC  = 4'd5,
    M_EMARK = 4'd6,
    M_ESIGN = 4'd7,
    M_EXP   = 4'd8,
    M_STR   = 4'd9,
    M_ESC   = 4'd10,
    M_KW    = 4'd11,
    M_ERR   = 4'd12
  } mode_e;

  typedef enum logic [3:0] {
    K_LBRACE    = 4'd0,
    K_RBRACE    = 4'd1,
    K_LBRACK    = 4'd2,
    K_RBRACK    = 4'd3,
    K_COMMA     = 4'd4,
    K_COLON     = 4'd5,
    K_INT_END   = 4'd6,
    K_FLOAT_END = 4'd7,
    K_STR_END   = 4'd8,
    K_KW_END    = 4'd9,
    K_EOT       = 4'd10,
    K_BYTE      = 4'd11,
    K_ERROR     = 4'd12
  } kind_e;

  typedef enum logic [3:0] {
    E_NONE        = 4'd0,
    E_LONE_MINUS  = 4'd1,
    E_NO_FRAC     = 4'd2,
    E_NO_EXP      = 4'd3,
    E_ESC_AT_END  = 4'd4,
    E_UNICODE_ESC = 4'd5,
    E_BAD_ESC     = 4'd6,
    E_UNTERM_STR  = 4'd7,
    E_UNEXPECTED  = 4'd8
  } err_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    err_e       err;
  } res_t;

  localparam int unsigned MaxRes = 3;

  // One lexing step: up to three results and the mode left behind.
  typedef struct packed {
    mode_e                  mode;
    logic [1:0]             cnt;
    res_t [MaxRes-1:0]      res;
  } step_t;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_LO_E   = 8'h65;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_U   = 8'h75;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;

endpackage

`default_nettype wire

// ===== hdl/jtl_step.sv =====
// Combinational lexing step: one item plus the current mode in, results out.
// Depends on jtl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jtl_step (
  input  jtl_pkg::mode_e mode_i,
  input  logic [7:0]     text_byte_i,
  input  logic           has_byte_i,
  input  logic           end_of_text_i,
  output jtl_pkg::step_t step_o
);
  import jtl_pkg::*;

  typedef struct packed {
    logic  hit;
    res_t  r;
    mode_e m;
  } idle_t;

  localparam res_t RES_NONE = '{kind: K_LBRACE, payload: 8'h00, err: E_NONE};

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic res_t mk(input kind_e k, input logic [7:0] p, input err_e e);
    res_t r;
    r.kind    = k;
    r.payload = p;
    r.err     = e;
    return r;
  endfunction

  // Byte seen between tokens; after_tok marks a byte that just closed a token.
  function automatic idle_t idle_byte(input logic [7:0] b, input logic after_tok);
    idle_t o;
    o.hit = 1'b1;
    o.r   = RES_NONE;
    o.m   = M_IDLE;
    case (b) inside
      CH_SPACE, CH_TAB, CH_LF, CH_CR: o.hit = 1'b0;
      CH_LBRACE: o.r = mk(K_LBRACE, 8'h00, E_NONE);
      CH_RBRACE: o.r = mk(K_RBRACE, 8'h00, E_NONE);
      CH_LBRACK: o.r = mk(K_LBRACK, 8'h00, E_NONE);
      CH_RBRACK: o.r = mk(K_RBRACK, 8'h00, E_NONE);
      CH_COMMA:  o.r = mk(K_COMMA, 8'h00, E_NONE);
      CH_COLON:  o.r = mk(K_COLON, 8'h00, E_NONE);
      CH_QUOTE: begin
        o.hit = 1'b0;
        o.m   = M_STR;
      end
      default: begin
        if (is_digit(b) || (b == CH_MINUS) || ((b >= CH_LO_A) && (b <= CH_LO_Z))) begin
          if (after_tok) begin
            o.r = mk(K_ERROR, 8'h00, E_UNEXPECTED);
            o.m = M_ERR;
          end else begin
            o.r = mk(K_BYTE, b, E_NONE);
            if (b == CH_MINUS)     o.m = M_SIGN;
            else if (b == CH_ZERO) o.m = M_ZERO;
            else if (is_digit(b))  o.m = M_INT;
            else                   o.m = M_KW;
          end
        end else begin
          o.r = mk(K_ERROR, 8'h00, E_UNEXPECTED);
          o.m = M_ERR;
        end
      end
    endcase
    return o;
  endfunction

  idle_t      ib_start;
  idle_t      ib_after;
  logic       dig;
  logic       emark;
  res_t [1:0] b_res;
  logic [1:0] b_cnt;
  mode_e      mid;
  res_t [1:0] e_res;
  logic [1:0] e_cnt;

  assign ib_start = idle_byte(text_byte_i, 1'b0);
  assign ib_after = idle_byte(text_byte_i, 1'b1);
  assign dig      = is_digit(text_byte_i);
  assign emark    = (text_byte_i == CH_LO_E) || (text_byte_i == CH_UP_E);

  // Byte part.
  always_comb begin
    b_res[0] = mk(K_BYTE, text_byte_i, E_NONE);
    b_res[1] = RES_NONE;
    b_cnt    = 2'd0;
    mid      = mode_i;
    if (has_byte_i) begin
      unique case (mode_i) inside
        M_IDLE: begin
          b_res[0] = ib_start.r;
          b_cnt    = {1'b0, ib_start.hit};
          mid      = ib_start.m;
        end
        M_SIGN: begin
          b_cnt = 2'd1;
          if (dig) begin
            mid = (text_byte_i == CH_ZERO) ? M_ZERO : M_INT;
          end else begin
            b_res[0] = mk(K_ERROR, 8'h00, E_LONE_MINUS);
            mid      = M_ERR;
          end
        end
        M_ZERO, M_INT: begin
          b_cnt = 2'd1;
          if ((mode_i == M_INT) && dig) begin
            mid = M_INT;
          end else if (text_byte_i == CH_DOT) begin
            mid = M_DOT;
          end else if (emark) begin
            mid = M_EMARK;
          end else begin
            b_res[0] = mk(K_INT_END, 8'h00, E_NONE);
            b_res[1] = ib_after.r;
            b_cnt    = ib_after.hit ? 2'd2 : 2'd1;
            mid      = ib_after.m;
          end
        end
        M_DOT: begin
          b_cnt = 2'd1;
          if (dig) begin
            mid = M_FRAC;
          end else begin
            b_res[0] = mk(K_ERROR, 8'h00, E_NO_FRAC);
            mid      = M_ERR;
          end
        end
        M_FRAC, M_EXP: begin
          b_cnt = 2'd1;
          if (dig) begin
            mid = mode_i;
          end else if (emark && (mode_i == M_FRAC)) begin
            mid = M_EMARK;
          end else begin
            b_res[0] = mk(K_FLOAT_END, 8'h00, E_NONE);
            b_res[1] = ib_after.r;
            b_cnt    = ib_after.hit ? 2'd2 : 2'd1;
            mid      = ib_after.m;
          end
        end
        M_EMARK, M_ESIGN: begin
          b_cnt = 2'd1;
          if (dig) begin
            mid = M_EXP;
          end else if ((mode_i == M_EMARK) &&
                       ((text_byte_i == CH_PLUS) || (text_byte_i == CH_MINUS))) begin
            mid = M_ESIGN;
          end else begin
            b_res[0] = mk(K_ERROR, 8'h00, E_NO_EXP);
            mid      = M_ERR;
          end
        end
        M_STR: begin
          if (text_byte_i == CH_BSLASH) begin
            mid = M_ESC;
          end else if (text_byte_i == CH_QUOTE) begin
            b_res[0] = mk(K_STR_END, 8'h00, E_NONE);
            b_cnt    = 2'd1;
            mid      = M_IDLE;
          end else begin
            b_cnt = 2'd1;
          end
        end
        M_ESC: begin
          b_cnt = 2'd1;
          mid   = M_STR;
          case (text_byte_i) inside
            CH_QUOTE, CH_SLASH, CH_BSLASH: b_res[0] = mk(K_BYTE, text_byte_i, E_NONE);
            CH_LO_B: b_res[0] = mk(K_BYTE, CH_BS, E_NONE);
            CH_LO_F: b_res[0] = mk(K_BYTE, CH_FF, E_NONE);
            CH_LO_N: b_res[0] = mk(K_BYTE, CH_LF, E_NONE);
            CH_LO_R: b_res[0] = mk(K_BYTE, CH_CR, E_NONE);
            CH_LO_T: b_res[0] = mk(K_BYTE, CH_TAB, E_NONE);
            CH_LO_U: begin
              b_res[0] = mk(K_ERROR, 8'h00, E_UNICODE_ESC);
              mid      = M_ERR;
            end
            default: begin
              b_res[0] = mk(K_ERROR, 8'h00, E_BAD_ESC);
              mid      = M_ERR;
            end
          endcase
        end
        M_KW: begin
          b_cnt = 2'd1;
          if (!(((text_byte_i >= CH_LO_A) && (text_byte_i <= CH_LO_Z)) ||
                ((text_byte_i >= CH_UP_A) && (text_byte_i <= CH_UP_Z)) ||
                dig || (text_byte_i == CH_UNDER))) begin
            b_res[0] = mk(K_KW_END, 8'h00, E_NONE);
            b_res[1] = ib_after.r;
            b_cnt    = ib_after.hit ? 2'd2 : 2'd1;
            mid      = ib_after.m;
          end
        end
        default: b_cnt = 2'd0;
      endcase
    end
  end

  // End-of-text part, from the mode the byte left.
  always_comb begin
    e_res[0] = mk(K_EOT, 8'h00, E_NONE);
    e_res[1] = mk(K_EOT, 8'h00, E_NONE);
    e_cnt    = 2'd0;
    if (end_of_text_i) begin
      unique case (mid) inside
        M_IDLE: e_cnt = 2'd1;
        M_SIGN: begin
          e_res[0] = mk(K_ERROR, 8'h00, E_LONE_MINUS);
          e_cnt    = 2'd1;
        end
        M_ZERO, M_INT: begin
          e_res[0] = mk(K_INT_END, 8'h00, E_NONE);
          e_cnt    = 2'd2;
        end
        M_DOT: begin
          e_res[0] = mk(K_ERROR, 8'h00, E_NO_FRAC);
          e_cnt    = 2'd1;
        end
        M_FRAC, M_EXP: begin
          e_res[0] = mk(K_FLOAT_END, 8'h00, E_NONE);
          e_cnt    = 2'd2;
        end
        M_EMARK, M_ESIGN: begin
          e_res[0] = mk(K_ERROR, 8'h00, E_NO_EXP);
          e_cnt    = 2'd1;
        end
        M_STR: begin
          e_res[0] = mk(K_ERROR, 8'h00, E_UNTERM_STR);
          e_cnt    = 2'd1;
        end
        M_ESC: begin
          e_res[0] = mk(K_ERROR, 8'h00, E_ESC_AT_END);
          e_cnt    = 2'd1;
        end
        M_KW: begin
          e_res[0] = mk(K_KW_END, 8'h00, E_NONE);
          e_cnt    = 2'd2;
        end
        default: e_cnt = 2'd0;
      endcase
    end
  end

  // Pack byte results first, then end results.
  always_comb begin
    step_o.mode   = end_of_text_i ? M_IDLE : mid;
    step_o.cnt    = b_cnt + e_cnt;
    step_o.res[0] = (b_cnt != 2'd0) ? b_res[0] : e_res[0];
    step_o.res[1] = (b_cnt == 2'd2) ? b_res[1] : ((b_cnt == 2'd1) ? e_res[0] : e_res[1]);
    step_o.res[2] = (b_cnt == 2'd2) ? e_res[0] : e_res[1];
  end

endmodule

`default_nettype wire

// ===== hdl/json_token_lexer_top.sv =====
// Streaming JSON token lexer, top level.
// Depends on jtl_pkg, jtl_step and json_token_lexer_top_defines.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request per item:
//   a text byte, has_byte_i (byte present) and end_of_text_i (text ends
//   after this item). Output channel (out_valid_o / out_ready_i) carries
//   one token result per transfer: kind, payload byte, error code and
//   last_of_run_o, which flags the last result caused by an input request.
//   An item causes zero to three results.
// Path: the first result of a request is valid after it has passed the
//   input register, then the result group; a busy result group holds it.
// Throughput: one request per cycle while out_ready_i is high and each
//   request causes at most one result; a request with more results holds
//   the output port (one result per cycle), which sets the sustained rate.
// Reset: clears the input register, the result group and the lexer mode
//   (idle between tokens); no item is pending afterwards.
// Stall: when out_ready_i is low the result group holds; the input
//   register then holds one more request and in_ready_o drops.
`timescale 1ns / 1ps
`default_nettype none

`include "json_token_lexer_top_defines.svh"

module json_token_lexer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] kind_o,
  output logic [7:0] payload_o,
  output logic [3:0] error_code_o,
  output logic       last_of_run_o
);
  import jtl_pkg::*;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_has_q;
  logic       in_eot_q;

  // Lexer mode, updated when an item moves into the result group.
  mode_e mode_q;

  // Result group: the results of one item, drained one per cycle while out_ready_i is high.
  res_t [MaxRes-1:0] grp_res_q;
  logic [1:0]        grp_cnt_q;
  logic [1:0]        grp_idx_q;

  step_t step;
  res_t  cur;
  logic  grp_last;
  logic  pop;
  logic  grp_free;
  logic  load;

  jtl_step u_step (
    .mode_i        (mode_q),
    .text_byte_i   (in_byte_q),
    .has_byte_i    (in_has_q),
    .end_of_text_i (in_eot_q),
    .step_o        (step)
  );

  // Group is free when empty or when its last result leaves this cycle.
  assign grp_last   = (grp_idx_q == (grp_cnt_q - 2'd1));
  assign out_valid_o = (grp_cnt_q != 2'd0);
  assign pop        = out_valid_o && out_ready_i;
  assign grp_free   = (grp_cnt_q == 2'd0) || (pop && grp_last);
  assign load       = in_vld_q && grp_free;
  assign in_ready_o = !in_vld_q || load;

  always_comb begin
    case (grp_idx_q)
      2'd0:    cur = grp_res_q[0];
      2'd1:    cur = grp_res_q[1];
      default: cur = grp_res_q[2];
    endcase
  end

  assign kind_o        = cur.kind;
  assign payload_o     = cur.payload;
  assign error_code_o  = cur.err;
  assign last_of_run_o = grp_last;

  // Input register: take a new request when empty or whenever the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= text_byte_i;
      in_has_q  <= has_byte_i;
      in_eot_q  <= end_of_text_i;
    end
  end

  // Mode and result group control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      grp_cnt_q <= 2'd0;
      grp_idx_q <= 2'd0;
    end else if (load) begin
      mode_q    <= step.mode;
      grp_cnt_q <= step.cnt;
      grp_idx_q <= 2'd0;
    end else if (pop) begin
      if (grp_last) begin
        grp_cnt_q <= 2'd0;
        grp_idx_q <= 2'd0;
      end else begin
        grp_idx_q <= grp_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_res_q <= step.res;
    end
  end

  // Checks.
  `JTL_ASSERT_NOW(a_idx_in_range, clk_i, rst_ni, out_valid_o, grp_idx_q < grp_cnt_q,
                  "result index beyond group count")
  `JTL_ASSERT_NOW(a_error_is_last, clk_i, rst_ni, out_valid_o && (kind_o == K_ERROR),
                  last_of_run_o, "error result not last of its run")
  `JTL_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_vld_q && !load,
                   in_vld_q && $stable(in_byte_q) && $stable(in_eot_q),
                   "held request lost or changed")
  `JTL_ASSERT_NEXT(a_load_restart, clk_i, rst_ni, load, grp_idx_q == 2'd0,
                   "group index not restarted on load")

endmodule

`default_nettype wire
